// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
// Both macros expect a signal named clk in the including scope; VTSA_ASSERT also rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VTSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VTSA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VTSA_ASSERT(label, prop, msg)
`define VTSA_ASSERT_RST(label, prop, msg)
`endif
`endif

// ----- rtl/vtsa_pkg.sv -----
// Package for the vector to spherical angles core: widths, queue item type,
// the arctangent table and the angle output conversion. No dependencies.
package vtsa_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int FRAC_BITS    = 16;

  localparam int IN_W     = 32;
  localparam int RAD_W    = 32;
  localparam int YAW_W    = FRAC_BITS + 9;
  localparam int PITCH_W  = FRAC_BITS + 10;
  localparam int ANG_FRAC = 30;
  localparam int GUARD    = 24;
  localparam int TAB_LEN  = 32;
  localparam int ANG_W    = 41;
  localparam int CW       = 60;
  localparam int HW       = IN_W + 1;
  localparam int SQ_STEPS = 32;
  localparam int CORE_DEPTH = (2 * CORDIC_STEPS > SQ_STEPS) ? 2 * CORDIC_STEPS : SQ_STEPS;
  localparam int QDEPTH   = 4;
  localparam int QAW      = 2;
  localparam int PP_W     = 47;
  localparam int GAIN_SH  = ANG_FRAC - GUARD;
  localparam int OUT_SH   = ANG_FRAC - FRAC_BITS;

  localparam logic [30:0] GAIN_Q30 = 31'd1768195363;
  localparam logic [63:0] RAD_TO_DEG_Q30 = 64'd61520874802;
  localparam logic signed [ANG_W-1:0] DEG_180 = ANG_W'(180) <<< ANG_FRAC;
  localparam logic signed [ANG_W-1:0] DEG_360 = ANG_W'(360) <<< ANG_FRAC;
  localparam logic signed [ANG_W-1:0] HALF_LSB = ANG_W'(1) <<< (OUT_SH - 1);
  localparam logic [YAW_W-1:0] FULL_TURN = YAW_W'(360) << FRAC_BITS;
  localparam logic [YAW_W-1:0] PITCH_UP  = YAW_W'(90) << FRAC_BITS;
  localparam logic [YAW_W-1:0] PITCH_DN  = YAW_W'(270) << FRAC_BITS;

  typedef logic signed [ANG_W-1:0] ang_tab_t [TAB_LEN];

  typedef struct packed {
    logic signed [HW-1:0]   hx;
    logic signed [HW-1:0]   hy;
    logic signed [IN_W-1:0] z;
    logic                   flip;
    logic                   spec;
  } vtsa_item_t;

  function automatic logic [63:0] long_div(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic ang_tab_t build_atan();
    ang_tab_t t;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] hi;
    logic [63:0] lo;
    int e;
    hi = RAD_TO_DEG_Q30 >> 18;
    lo = RAD_TO_DEG_Q30 & 64'h3FFFF;
    t[0] = ANG_W'(45) <<< ANG_FRAC;
    for (int i = 1; i < TAB_LEN; i++) begin
      sum = '0;
      for (int k = 0; k < 32; k++) begin
        e = i * (2 * k + 1);
        if (e <= 62) begin
          term = long_div(64'(1) << (62 - e), 64'(2 * k + 1));
          if (k % 2 == 1) sum = sum - term;
          else sum = sum + term;
        end
      end
      r = sum >> 30;
      t[i] = ANG_W'(((r * hi) >> 14) + ((r * lo) >> 32));
    end
    return t;
  endfunction

  localparam ang_tab_t ATAN_TAB = build_atan();

  function automatic logic [YAW_W-1:0] to_output(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] w;
    logic signed [ANG_W-1:0] q;
    w = a[ANG_W-1] ? a + DEG_360 : a;
    q = (w + HALF_LSB) >>> OUT_SH;
    if (q >= ANG_W'(FULL_TURN)) q = q - ANG_W'(FULL_TURN);
    return q[YAW_W-1:0];
  endfunction

endpackage

// ----- rtl/vtsa_if.sv -----
// Valid/ready channel interfaces for vectors in and angle results out.
// Depends on vtsa_pkg for field widths.
interface vtsa_in_if import vtsa_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] vec_x;
  logic signed [IN_W-1:0] vec_y;
  logic signed [IN_W-1:0] vec_z;
  modport source (output valid, vec_x, vec_y, vec_z, input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface vtsa_out_if import vtsa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [RAD_W-1:0]          radius;
  logic [YAW_W-1:0]          yaw_deg;
  logic signed [PITCH_W-1:0] neg_pitch_deg;
  modport source (output valid, radius, yaw_deg, neg_pitch_deg, input ready);
  modport sink (input valid, radius, yaw_deg, neg_pitch_deg, output ready);
endinterface

// ----- rtl/vtsa_front.sv -----
// Front end: takes input beats, flips vectors with negative x and flags the
// zero horizontal case. Depends on vtsa_pkg and vtsa_in_if.
module vtsa_front import vtsa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  vtsa_in_if.sink    in_bus,
  output vtsa_item_t item,
  output logic       item_valid,
  input  logic       item_ready
);

  logic       v_r;
  vtsa_item_t item_r;
  vtsa_item_t item_nxt;
  logic signed [HW-1:0] xs;
  logic signed [HW-1:0] ys;

  assign in_bus.ready = !v_r || item_ready;
  assign item         = item_r;
  assign item_valid   = v_r;

  always_comb begin
    xs = HW'(in_bus.vec_x);
    ys = HW'(in_bus.vec_y);
    item_nxt.flip = in_bus.vec_x[IN_W-1];
    item_nxt.hx   = item_nxt.flip ? -xs : xs;
    item_nxt.hy   = item_nxt.flip ? -ys : ys;
    item_nxt.z    = in_bus.vec_z;
    item_nxt.spec = (in_bus.vec_x == '0) && (in_bus.vec_y == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_bus.valid && in_bus.ready) begin
      v_r <= 1'b1;
    end else if (item_ready) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ----- rtl/vtsa_fifo.sv -----
// Short queue between the front end and the CORDIC back end.
// Depends on vtsa_pkg and assert_macros.svh.
`include "assert_macros.svh"
module vtsa_fifo import vtsa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  vtsa_item_t wr_item,
  input  logic       wr_valid,
  output logic       wr_ready,
  output vtsa_item_t rd_item,
  output logic       rd_valid,
  input  logic       rd_ready
);

  vtsa_item_t       mem_r [QDEPTH];
  logic [QAW-1:0]   wp_r;
  logic [QAW-1:0]   rp_r;
  logic [QAW:0]     cnt_r;
  logic             push;
  logic             pop;

  assign wr_ready = cnt_r < (QAW+1)'(QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_item  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_item;
  end

  `VTSA_ASSERT(a_cnt_max, cnt_r <= (QAW+1)'(QDEPTH), "queue count exceeds depth")
  `VTSA_ASSERT(a_ptr_gap, (wp_r - rp_r) == cnt_r[QAW-1:0], "queue pointers disagree with count")
  `VTSA_ASSERT(a_cnt_up, (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1), "queue count lost a push")

endmodule

// ----- rtl/vtsa_back.sv -----
// Back end: squares and gain product, pipelined square root, yaw and pitch
// CORDIC vectoring stages, output conversion and output register.
// Depends on vtsa_pkg and vtsa_out_if.
module vtsa_back import vtsa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  vtsa_item_t q_item,
  input  logic       q_valid,
  output logic       q_ready,
  vtsa_out_if.source out_bus
);

  logic en;
  logic out_v_r;

  logic                 a_v_r;
  vtsa_item_t           a_item_r;
  logic [63:0]          a_sqx_r;
  logic [63:0]          a_sqy_r;
  logic [63:0]          a_sqz_r;
  logic [PP_W-1:0]      a_pph_r;
  logic [PP_W-1:0]      a_ppl_r;
  logic [HW-1:0]        ax;
  logic [HW-1:0]        ay;
  logic [IN_W-1:0]      az;
  logic [62:0]          zprod;
  logic [CW-1:0]        zk;

  logic                    c_v_r    [CORE_DEPTH+1];
  logic                    c_spec_r [CORE_DEPTH+1];
  logic                    c_zpos_r [CORE_DEPTH+1];
  logic signed [CW-1:0]    c_x_r    [CORE_DEPTH+1];
  logic signed [CW-1:0]    c_y_r    [CORE_DEPTH+1];
  logic signed [CW-1:0]    c_gz_r   [CORE_DEPTH+1];
  logic signed [ANG_W-1:0] c_a_r    [CORE_DEPTH+1];
  logic signed [ANG_W-1:0] c_yaw_r  [CORE_DEPTH+1];
  logic [63:0]             c_rem_r  [CORE_DEPTH+1];
  logic [63:0]             c_res_r  [CORE_DEPTH+1];

  logic [RAD_W-1:0]          rad_r;
  logic [YAW_W-1:0]          yaw_r;
  logic signed [PITCH_W-1:0] pit_r;
  logic [YAW_W-1:0]          pitch_pos;
  logic [YAW_W-1:0]          yaw_pos;

  assign en      = !out_v_r || out_bus.ready;
  assign q_ready = en;

  always_comb begin
    ax = q_item.hx[HW-1] ? HW'(-q_item.hx) : HW'(q_item.hx);
    ay = q_item.hy[HW-1] ? HW'(-q_item.hy) : HW'(q_item.hy);
    az = q_item.z[IN_W-1] ? IN_W'(-q_item.z) : IN_W'(q_item.z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item_r <= q_item;
      a_sqx_r  <= ax[IN_W-1:0] * ax[IN_W-1:0];
      a_sqy_r  <= ay[IN_W-1:0] * ay[IN_W-1:0];
      a_sqz_r  <= az * az;
      a_pph_r  <= az[31:16] * GAIN_Q30;
      a_ppl_r  <= az[15:0] * GAIN_Q30;
    end
  end

  always_comb begin
    zprod = (63'(a_pph_r) << 16) + 63'(a_ppl_r);
    zk    = CW'(zprod >> GAIN_SH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r[0] <= 1'b0;
    end else if (en) begin
      c_v_r[0] <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_spec_r[0] <= a_item_r.spec;
      c_zpos_r[0] <= !a_item_r.z[IN_W-1] && (a_item_r.z != '0);
      c_x_r[0]    <= CW'(a_item_r.hx) <<< GUARD;
      c_y_r[0]    <= CW'(a_item_r.hy) <<< GUARD;
      c_gz_r[0]   <= a_item_r.z[IN_W-1] ? -zk : zk;
      c_a_r[0]    <= a_item_r.flip ? DEG_180 : '0;
      c_yaw_r[0]  <= '0;
      c_rem_r[0]  <= a_sqx_r + a_sqy_r + a_sqz_r;
      c_res_r[0]  <= '0;
    end
  end

  for (genvar j = 0; j < CORE_DEPTH; j++) begin : g_stage
    localparam bit ACT   = j < 2 * CORDIC_STEPS;
    localparam bit START = j == CORDIC_STEPS;
    localparam int SH    = (j < CORDIC_STEPS) ? j : ((j < 2 * CORDIC_STEPS) ? j - CORDIC_STEPS : 0);
    localparam bit SQA   = j < SQ_STEPS;
    localparam int BS    = SQA ? 62 - 2 * j : 0;

    logic signed [CW-1:0]    xi;
    logic signed [CW-1:0]    yi;
    logic signed [CW-1:0]    xo;
    logic signed [CW-1:0]    yo;
    logic signed [ANG_W-1:0] ai;
    logic signed [ANG_W-1:0] ao;
    logic [63:0]             bitv;
    logic [64:0]             trial;
    logic [63:0]             rem_o;
    logic [63:0]             res_o;

    assign xi   = c_x_r[j];
    assign yi   = START ? c_gz_r[j] : c_y_r[j];
    assign ai   = START ? '0 : c_a_r[j];
    assign bitv = 64'(1) << BS;

    always_comb begin
      if (!ACT) begin
        xo = xi;
        yo = yi;
        ao = ai;
      end else if (!yi[CW-1]) begin
        xo = xi + (yi >>> SH);
        yo = yi - (xi >>> SH);
        ao = ai + ATAN_TAB[SH];
      end else begin
        xo = xi - (yi >>> SH);
        yo = yi + (xi >>> SH);
        ao = ai - ATAN_TAB[SH];
      end
    end

    always_comb begin
      trial = {1'b0, c_res_r[j]} + {1'b0, bitv};
      if (!SQA) begin
        rem_o = c_rem_r[j];
        res_o = c_res_r[j];
      end else if ({1'b0, c_rem_r[j]} >= trial) begin
        rem_o = c_rem_r[j] - trial[63:0];
        res_o = (c_res_r[j] >> 1) + bitv;
      end else begin
        rem_o = c_rem_r[j];
        res_o = c_res_r[j] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_v_r[j+1] <= 1'b0;
      end else if (en) begin
        c_v_r[j+1] <= c_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_spec_r[j+1] <= c_spec_r[j];
        c_zpos_r[j+1] <= c_zpos_r[j];
        c_x_r[j+1]    <= xo;
        c_y_r[j+1]    <= yo;
        c_gz_r[j+1]   <= c_gz_r[j];
        c_a_r[j+1]    <= ao;
        c_yaw_r[j+1]  <= START ? c_a_r[j] : c_yaw_r[j];
        c_rem_r[j+1]  <= rem_o;
        c_res_r[j+1]  <= res_o;
      end
    end
  end

  always_comb begin
    if (c_spec_r[CORE_DEPTH]) begin
      yaw_pos   = '0;
      pitch_pos = c_zpos_r[CORE_DEPTH] ? PITCH_UP : PITCH_DN;
    end else begin
      yaw_pos   = to_output(c_yaw_r[CORE_DEPTH]);
      pitch_pos = to_output(c_a_r[CORE_DEPTH]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= c_v_r[CORE_DEPTH];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r <= RAD_W'(c_res_r[CORE_DEPTH]
               + 64'(c_rem_r[CORE_DEPTH] > c_res_r[CORE_DEPTH]));
      yaw_r <= yaw_pos;
      pit_r <= -$signed({1'b0, pitch_pos});
    end
  end

  assign out_bus.valid         = out_v_r;
  assign out_bus.radius        = rad_r;
  assign out_bus.yaw_deg       = yaw_r;
  assign out_bus.neg_pitch_deg = pit_r;

endmodule

// ----- rtl/vector_to_spherical_angles_core.sv -----
// Vector to spherical angles core: radius, yaw and negated pitch of a vector.
// Beats pass the front register, the queue, the squares register, the core input
// register, CORE_DEPTH stages of both CORDIC chains and the output register.
// Throughput is one beat per cycle; the back end stalls as a whole on output.
// Reset is synchronous active low and empties the front, queue and pipeline.
module vector_to_spherical_angles_core import vtsa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  vtsa_in_if.sink    in_bus,
  vtsa_out_if.source out_bus
);

  vtsa_item_t f_item;
  logic       f_valid;
  logic       f_ready;
  vtsa_item_t q_item;
  logic       q_valid;
  logic       q_ready;

  vtsa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .item       (f_item),
    .item_valid (f_valid),
    .item_ready (f_ready)
  );

  vtsa_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_item  (f_item),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_item  (q_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  vtsa_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .out_bus (out_bus)
  );

endmodule

// ----- tb/sv/vtsa_angle_checker.sv -----
// Checker for the vector to spherical angles core: watches both channels,
// predicts radius, yaw and negated pitch for every accepted vector and compares.
// Depends on vtsa_pkg and the channel interfaces in vtsa_if.sv.
module vtsa_angle_checker import vtsa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  vtsa_in_if   in_mon,
  vtsa_out_if  out_mon,
  output int   mismatches,
  output int   outstanding,
  output int   checked
);

  typedef struct {
    logic [RAD_W-1:0]          radius;
    logic [YAW_W-1:0]          yaw;
    logic signed [PITCH_W-1:0] npitch;
  } angles_t;

  localparam longint DEG_ONE = longint'(1) << ANG_FRAC;
  localparam longint unsigned DEG_SCALE = 64'd61520874802;
  localparam longint unsigned GAIN_K = 64'd1768195363;

  longint  atan_deg [TAB_LEN];
  angles_t expected_angles [$];

  initial begin
    longint unsigned sum;
    longint unsigned term;
    longint unsigned r;
    int k;
    mismatches = 0;
    checked = 0;
    atan_deg[0] = 45 * DEG_ONE;
    for (int i = 1; i < TAB_LEN; i++) begin
      sum = 0;
      k = 0;
      while (i * (2 * k + 1) <= 62) begin
        term = (longint'(1) << (62 - i * (2 * k + 1))) / longint'(2 * k + 1);
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
        k++;
      end
      r = sum >> 30;
      atan_deg[i] = longint'(((r * (DEG_SCALE >> 18)) >> 14) +
                             ((r * (DEG_SCALE & 64'h3FFFF)) >> 32));
    end
  end

  assign outstanding = expected_angles.size();

  function automatic longint unsigned isqrt_round(input longint unsigned v);
    longint unsigned rem;
    longint unsigned res;
    longint unsigned bitv;
    rem = v;
    res = 0;
    bitv = longint'(1) << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    if (rem > res) res++;
    return res;
  endfunction

  function automatic longint cordic_vectoring(input longint x0, input longint y0,
                                              output longint xf);
    longint x;
    longint y;
    longint a;
    longint dx;
    longint dy;
    x = x0;
    y = y0;
    a = 0;
    for (int i = 0; i < CORDIC_STEPS && i < TAB_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        a = a + atan_deg[i];
      end else begin
        x = x - dx;
        y = y + dy;
        a = a - atan_deg[i];
      end
    end
    xf = x;
    return a;
  endfunction

  function automatic longint degrees_to_out(input longint a);
    longint q;
    if (a < 0) a = a + 360 * DEG_ONE;
    q = (a + (longint'(1) << (OUT_SH - 1))) >>> OUT_SH;
    if (q >= (longint'(360) << FRAC_BITS)) q = q - (longint'(360) << FRAC_BITS);
    return q;
  endfunction

  function automatic angles_t predict_angles(input logic signed [IN_W-1:0] vx,
                                             input logic signed [IN_W-1:0] vy,
                                             input logic signed [IN_W-1:0] vz);
    angles_t r;
    longint x;
    longint y;
    longint z;
    longint unsigned mx;
    longint unsigned my;
    longint unsigned mz;
    longint gx;
    longint gy;
    longint gz;
    longint hx;
    longint base;
    longint pitch;
    longint yaw;
    longint unsigned zk;
    x = vx;
    y = vy;
    z = vz;
    mx = x < 0 ? -x : x;
    my = y < 0 ? -y : y;
    mz = z < 0 ? -z : z;
    r.radius = RAD_W'(isqrt_round(mx * mx + my * my + mz * mz));
    if (x == 0 && y == 0) begin
      yaw = 0;
      pitch = (z > 0 ? 90 : 270) << FRAC_BITS;
    end else begin
      gx = x <<< GUARD;
      gy = y <<< GUARD;
      base = 0;
      if (gx < 0) begin
        gx = -gx;
        gy = -gy;
        base = 180 * DEG_ONE;
      end
      yaw = degrees_to_out(base + cordic_vectoring(gx, gy, hx));
      zk = (mz * GAIN_K) >> (ANG_FRAC - GUARD);
      gz = z < 0 ? -longint'(zk) : longint'(zk);
      pitch = degrees_to_out(cordic_vectoring(hx, gz, gx));
    end
    r.yaw = YAW_W'(yaw);
    r.npitch = PITCH_W'(0 - pitch);
    return r;
  endfunction

  task automatic report(input string field, input longint want, input longint got);
    $display("mismatch on result %0d: %s expected 0x%0h, got 0x%0h",
             checked, field, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    angles_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready)
        expected_angles.push_back(predict_angles(in_mon.vec_x, in_mon.vec_y, in_mon.vec_z));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_angles.size() == 0) begin
          $display("result beat with no vector waiting for it");
          mismatches++;
        end else begin
          want = expected_angles.pop_front();
          if (out_mon.radius !== want.radius)
            report("radius", want.radius, out_mon.radius);
          if (out_mon.yaw_deg !== want.yaw)
            report("yaw_deg", want.yaw, out_mon.yaw_deg);
          if (out_mon.neg_pitch_deg !== want.npitch)
            report("neg_pitch_deg", want.npitch, out_mon.neg_pitch_deg);
        end
        checked++;
      end
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the testbench: clock, reset, vector stimulus with bursty sending and
// a stalling receiver. Depends on vtsa_pkg, vtsa_if.sv, the core and the checker.
module testbench import vtsa_pkg::*;;

  localparam int RANDOM_VECS = 1550;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = CORE_DEPTH + 20;

  logic clk;
  logic rst_n;
  int   cycles = 0;
  int   mismatches;
  int   outstanding;
  int   checked;
  int   burst_left;
  int   sent;

  vtsa_in_if  in_bus ();
  vtsa_out_if out_bus ();

  vector_to_spherical_angles_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  vtsa_angle_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The receiver runs through four stall habits, picked from bits of the cycle counter.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      case ((cycles >> 8) % 4)
        0: begin
          out_bus.ready <= 1'b1;
        end
        1: begin
          out_bus.ready <= 1'($urandom_range(1, 0));
        end
        2: begin
          out_bus.ready <= ($urandom_range(3, 0) == 0);
        end
        default: begin
          out_bus.ready <= ($urandom_range(9, 0) != 0);
        end
      endcase
    end
  end

  task automatic send_vec(input logic signed [IN_W-1:0] x, input logic signed [IN_W-1:0] y,
                          input logic signed [IN_W-1:0] z);
    in_bus.valid <= 1'b1;
    in_bus.vec_x <= x;
    in_bus.vec_y <= y;
    in_bus.vec_z <= z;
    do @(posedge clk); while (!in_bus.ready);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(30, 1);
      if ($urandom_range(2, 0) != 0) begin
        in_bus.valid <= 1'b0;
        repeat ($urandom_range(8, 1)) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic signed [IN_W-1:0] pick_component();
    case ($urandom_range(9, 0))
      0: return '0;
      1: return $urandom_range(1, 0) ? 32'sh7FFFFFFF : 32'sh80000000;
      2, 3: return IN_W'($signed($urandom_range(131072, 0)) - 65536);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic signed [IN_W-1:0] vx;
    logic signed [IN_W-1:0] vy;
    logic signed [IN_W-1:0] vz;
    sent = 0;
    burst_left = 0;
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.vec_x <= '0;
    in_bus.vec_y <= '0;
    in_bus.vec_z <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero horizontal part: straight up, straight down and the origin.
    send_vec(0, 0, 32'sh00010000);
    send_vec(0, 0, -32'sh00010000);
    send_vec(0, 0, 0);
    send_vec(0, 0, 32'sh7FFFFFFF);
    send_vec(0, 0, 32'sh80000000);
    // Extremes of every component.
    send_vec(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_vec(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_vec(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
    send_vec(32'sh7FFFFFFF, 32'sh80000000, 0);
    send_vec(32'sh00000001, 0, 0);
    send_vec(-32'sh00000001, 0, 0);
    // Axes and negative x, which is turned by a half circle first.
    send_vec(0, 32'sh00010000, 0);
    send_vec(0, -32'sh00010000, 0);
    send_vec(-32'sh00010000, 32'sh00010000, 32'sh00010000);
    send_vec(-32'sh00010000, -32'sh00010000, -32'sh00010000);
    send_vec(-32'sh00010000, 0, 0);
    // Tiny negative angle, which rounds up to a full turn and wraps to zero.
    send_vec(32'sh7FFFFFFF, -32'sh00000001, 0);
    send_vec(32'sh7FFFFFFF, 0, -32'sh00000001);
    send_vec(32'sh40000000, -32'sh00000001, -32'sh00000001);
    send_vec(32'sh00030000, 32'sh00040000, 32'sh000C0000);
    wait_drained();

    for (int n = 0; n < RANDOM_VECS; n++) begin
      vx = pick_component();
      vy = pick_component();
      vz = pick_component();
      if ($urandom_range(19, 0) == 0) begin
        vx = '0;
        vy = '0;
      end
      send_vec(vx, vy, vz);
      if (n == RANDOM_VECS / 2) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d vectors and checked %0d results, covering zero horizontal parts,",
             sent, checked);
    $display("extreme components, wrap at a full turn and random stalls on both sides.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- vector_to_spherical_angles_core.f -----
+incdir+rtl
rtl/vtsa_pkg.sv
rtl/vtsa_if.sv
rtl/vtsa_front.sv
rtl/vtsa_fifo.sv
rtl/vtsa_back.sv
rtl/vector_to_spherical_angles_core.sv
tb/sv/vtsa_angle_checker.sv
tb/sv/testbench.sv
